[rtl/fpc_pkg.sv]
// Shared constants, status codes and the result record for the frame checker.
// No dependencies; every other file imports this package.
package fpc_pkg;

    localparam int unsigned HDR_BYTES       = 26;
    localparam int unsigned CRC_BYTES       = 4;
    localparam int unsigned MAX_PAYLOAD_DEF = 256;
    localparam int unsigned TAIL_DEPTH      = 4;
    localparam int unsigned CMP_W           = 18;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [7:0] EXP_MAJOR_RST = 8'd1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_BAD_VER   = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;
    localparam logic [2:0] ST_BAD_CRC   = 3'd5;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [15:0] version;
        logic [7:0]  msg_type;
        logic [7:0]  flags;
        logic [15:0] declared_len;
        logic [31:0] sess_id;
        logic [31:0] sequence_res;
        logic [31:0] acknowledgement;
        logic [63:0] tx_stamp_us;
    } result_t;

endpackage

[rtl/fpc_crc_step.sv]
// One-byte step of the reflected CRC-32C, unrolled over eight bit positions.
// Depends on fpc_pkg for the polynomial.
module fpc_crc_step
    import fpc_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        crc_out = c;
    end

endmodule

[rtl/fpc_frame.sv]
// Frame state: byte counter, CRC register, tail delay line and header capture.
// Produces the result of each accepted byte. Depends on fpc_pkg, fpc_crc_step.
module fpc_frame
    import fpc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        end_of_body,
    input  logic [7:0]  expected_major_version,
    output logic        emit,
    output result_t     res
);

    localparam int unsigned MAX_BODY = HDR_BYTES + MAX_PAYLOAD + CRC_BYTES;
    localparam int unsigned CNT_W    = $clog2(MAX_BODY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [31:0]      crc_reg;
    logic [31:0]      crc_next;
    logic [31:0]      crc_step;
    logic [7:0]       tail_reg [TAIL_DEPTH];
    logic [7:0]       hdr_reg  [HDR_BYTES];

    logic [CMP_W-1:0] n_ext;
    logic [CMP_W-1:0] size;
    logic [CMP_W-1:0] plen_ext;
    logic [15:0]      plen;
    logic [31:0]      rx_crc;
    logic             pass_byte;
    logic [2:0]       st;

    fpc_crc_step u_crc_step (
        .crc_in  (crc_reg),
        .data_in (tail_reg[TAIL_DEPTH-1]),
        .crc_out (crc_step)
    );

    assign plen     = {hdr_reg[5], hdr_reg[4]};
    assign n_ext    = CMP_W'(count_reg);
    assign size     = n_ext + CMP_W'(1);
    assign plen_ext = CMP_W'(plen);
    assign crc_next = (n_ext >= CMP_W'(TAIL_DEPTH)) ? crc_step : crc_reg;
    assign rx_crc   = {data_byte, tail_reg[0], tail_reg[1], tail_reg[2]};

    assign pass_byte = (n_ext >= CMP_W'(HDR_BYTES))
                    && (n_ext < CMP_W'(HDR_BYTES) + plen_ext)
                    && (n_ext < CMP_W'(HDR_BYTES + MAX_PAYLOAD));

    always_comb
    begin
        if (size < CMP_W'(HDR_BYTES + CRC_BYTES))
            st = ST_SHORT;
        else if (size > CMP_W'(MAX_BODY))
            st = ST_TOO_LARGE;
        else if (hdr_reg[1] != expected_major_version)
            st = ST_BAD_VER;
        else if (size != CMP_W'(HDR_BYTES + CRC_BYTES) + plen_ext)
            st = ST_BAD_LEN;
        else if ((crc_next ^ CRC_INIT) != rx_crc)
            st = ST_BAD_CRC;
        else
            st = ST_OK;
    end

    always_comb
    begin
        res  = '0;
        emit = 1'b0;
        if (end_of_body)
        begin
            emit          = 1'b1;
            res.item_kind = KIND_VERDICT;
            res.status    = st;
            if (st == ST_OK)
            begin
                res.version         = {hdr_reg[1], hdr_reg[0]};
                res.msg_type        = hdr_reg[2];
                res.flags           = hdr_reg[3];
                res.declared_len    = plen;
                res.sess_id         = {hdr_reg[9], hdr_reg[8], hdr_reg[7], hdr_reg[6]};
                res.sequence_res    = {hdr_reg[13], hdr_reg[12], hdr_reg[11], hdr_reg[10]};
                res.acknowledgement = {hdr_reg[17], hdr_reg[16], hdr_reg[15], hdr_reg[14]};
                res.tx_stamp_us     = {hdr_reg[25], hdr_reg[24], hdr_reg[23], hdr_reg[22],
                                       hdr_reg[21], hdr_reg[20], hdr_reg[19], hdr_reg[18]};
            end
        end
        else if (pass_byte)
        begin
            emit             = 1'b1;
            res.item_kind    = KIND_PAYLOAD;
            res.payload_byte = data_byte;
        end
    end

    always_comb
    begin
        if (end_of_body)
            count_next = '0;
        else if (count_reg < CNT_W'(MAX_BODY))
            count_next = count_reg + CNT_W'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            crc_reg   <= end_of_body ? CRC_INIT : crc_next;
        end
    end

    // advance delay line and capture header bytes
    always_ff @(posedge clk)
    begin
        if (accept && !end_of_body)
        begin
            tail_reg[0] <= data_byte;
            for (int i = 1; i < TAIL_DEPTH; i++)
            begin
                tail_reg[i] <= tail_reg[i-1];
            end
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                if (n_ext == CMP_W'(i))
                    hdr_reg[i] <= data_byte;
            end
        end
    end

endmodule

[rtl/framed_packet_checker_crc32c.sv]
// Streaming frame checker with CRC-32C, top level.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless a result is held and out_ready is low.
// Reset (rst_n, async low) clears the counter, CRC, output valid and sets the
// expected major version to 1. No clearing pass is needed.
module framed_packet_checker_crc32c
    import fpc_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_body,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        item_kind,
    output logic [7:0]  payload_byte,
    output logic [2:0]  status,
    output logic [15:0] version,
    output logic [7:0]  msg_type,
    output logic [7:0]  flags,
    output logic [15:0] declared_len,
    output logic [31:0] sess_id,
    output logic [31:0] sequence_res,
    output logic [31:0] acknowledgement,
    output logic [63:0] tx_stamp_us
);

    logic [7:0] exp_major_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;
    result_t    res;
    logic       emit;
    logic       accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    fpc_frame #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .accept                 (accept),
        .data_byte              (data_byte),
        .end_of_body            (end_of_body),
        .expected_major_version (exp_major_reg),
        .emit                   (emit),
        .res                    (res)
    );

    always_comb
    begin
        if (accept)
            out_valid_next = emit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_major_reg <= EXP_MAJOR_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                exp_major_reg <= cfg_write_data;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold result until taken
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            out_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign item_kind       = out_reg.item_kind;
    assign payload_byte    = out_reg.payload_byte;
    assign status          = out_reg.status;
    assign version         = out_reg.version;
    assign msg_type        = out_reg.msg_type;
    assign flags           = out_reg.flags;
    assign declared_len    = out_reg.declared_len;
    assign sess_id         = out_reg.sess_id;
    assign sequence_res    = out_reg.sequence_res;
    assign acknowledgement = out_reg.acknowledgement;
    assign tx_stamp_us     = out_reg.tx_stamp_us;

endmodule

[rtl/fpc_checker.sv]
// Port-level checker for the frame checker, bound to its top level.
// Depends on fpc_pkg for kind and status codes.
module fpc_checker
    import fpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        end_of_body,
    input logic        out_valid,
    input logic        out_ready,
    input logic        item_kind,
    input logic [7:0]  payload_byte,
    input logic [2:0]  status,
    input logic [15:0] version,
    input logic [31:0] sess_id,
    input logic [63:0] tx_stamp_us
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind)
            && $stable(payload_byte) && $stable(status))
        else $error("result changed while stalled");

    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_body |=> out_valid && item_kind == KIND_VERDICT)
        else $error("final byte produced no verdict");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_PAYLOAD |-> status == ST_OK && version == 16'd0)
        else $error("payload transaction carries header data");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_VERDICT && status != ST_OK
            |-> version == 16'd0 && sess_id == 32'd0 && tx_stamp_us == 64'd0
                && payload_byte == 8'd0)
        else $error("failed verdict carries header data");

endmodule

bind framed_packet_checker_crc32c fpc_checker u_fpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .end_of_body  (end_of_body),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .item_kind    (item_kind),
    .payload_byte (payload_byte),
    .status       (status),
    .version      (version),
    .sess_id      (sess_id),
    .tx_stamp_us  (tx_stamp_us)
);

[bench/framed_packet_checker_crc32c_tb.sv]
// Self-checking bench for framed_packet_checker_crc32c: frame stimulus, CRC-32C
// prediction and a result scoreboard. Depends on fpc_pkg and the block's RTL only.
package frame_check_tb_pkg;
    import fpc_pkg::*;

    function automatic logic [31:0] crc32c_step(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        int          k;
        c = crc ^ {24'h0, b};
        for (k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    class frame_scoreboard;
        result_t     pending_q[$];
        logic [7:0]  major;
        int unsigned body_count;
        int unsigned body_limit;
        int unsigned payload_cap;
        logic [31:0] crc_reg;
        logic [7:0]  tail[TAIL_DEPTH];
        logic [7:0]  hdr[HDR_BYTES];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned payloads_seen;
        int unsigned verdicts_seen[6];

        function new(int unsigned cap);
            payload_cap = cap;
            body_limit  = HDR_BYTES + cap + CRC_BYTES;
            major       = EXP_MAJOR_RST;
            mismatches  = 0;
            checked     = 0;
            payloads_seen = 0;
            foreach (verdicts_seen[i])
                verdicts_seen[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            body_count = 0;
            crc_reg    = CRC_INIT;
            foreach (tail[i])
                tail[i] = '0;
            foreach (hdr[i])
                hdr[i] = '0;
        endfunction

        function logic [63:0] hdr_le(int unsigned pos, int unsigned len);
            logic [63:0] v;
            int unsigned k;
            v = '0;
            for (k = 0; k < len; k++)
                v[8*k +: 8] = hdr[pos + k];
            return v;
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction

        function void note_input(logic [7:0] b, logic last);
            result_t     r;
            logic [31:0] crc_n;
            logic [31:0] rx_crc;
            int unsigned plen;
            int unsigned body_size;
            int          i;
            plen  = 32'(hdr_le(4, 2));
            crc_n = crc_reg;
            if (body_count >= TAIL_DEPTH)
                crc_n = crc32c_step(crc_reg, tail[3]);
            r = '0;
            if (last)
            begin
                body_size = body_count + 1;
                rx_crc    = {b, tail[0], tail[1], tail[2]};
                r.item_kind = KIND_VERDICT;
                if (body_size < HDR_BYTES + CRC_BYTES)
                    r.status = ST_SHORT;
                else if (body_size > body_limit)
                    r.status = ST_TOO_LARGE;
                else if (hdr[1] != major)
                    r.status = ST_BAD_VER;
                else if (body_size != HDR_BYTES + plen + CRC_BYTES)
                    r.status = ST_BAD_LEN;
                else if ((crc_n ^ CRC_INIT) != rx_crc)
                    r.status = ST_BAD_CRC;
                else
                    r.status = ST_OK;
                if (r.status == ST_OK)
                begin
                    r.version         = 16'(hdr_le(0, 2));
                    r.msg_type        = hdr[2];
                    r.flags           = hdr[3];
                    r.declared_len    = 16'(plen);
                    r.sess_id         = 32'(hdr_le(6, 4));
                    r.sequence_res    = 32'(hdr_le(10, 4));
                    r.acknowledgement = 32'(hdr_le(14, 4));
                    r.tx_stamp_us     = hdr_le(18, 8);
                end
                pending_q = {pending_q, r};
                clear_frame();
                return;
            end
            if (body_count < HDR_BYTES)
                hdr[body_count] = b;
            else if (body_count < HDR_BYTES + plen && body_count < HDR_BYTES + payload_cap)
            begin
                r.item_kind    = KIND_PAYLOAD;
                r.payload_byte = b;
                pending_q = {pending_q, r};
            end
            for (i = TAIL_DEPTH - 1; i > 0; i--)
                tail[i] = tail[i - 1];
            tail[0] = b;
            crc_reg = crc_n;
            if (body_count < body_limit)
                body_count++;
        endfunction

        function int unsigned field_differs(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                if (mismatches < 10)
                    $display("result %0d %s: expected %0h, got %0h",
                             checked, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_result(result_t got);
            result_t     want;
            int unsigned bad;
            checked++;
            if (pending_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d arrived with nothing expected (kind %0b)",
                             checked, got.item_kind);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            bad  = 0;
            bad += field_differs("item_kind", 64'(want.item_kind), 64'(got.item_kind));
            bad += field_differs("payload_byte", 64'(want.payload_byte),
                                 64'(got.payload_byte));
            bad += field_differs("status", 64'(want.status), 64'(got.status));
            bad += field_differs("version", 64'(want.version), 64'(got.version));
            bad += field_differs("msg_type", 64'(want.msg_type), 64'(got.msg_type));
            bad += field_differs("flags", 64'(want.flags), 64'(got.flags));
            bad += field_differs("declared_len", 64'(want.declared_len),
                                 64'(got.declared_len));
            bad += field_differs("sess_id", 64'(want.sess_id), 64'(got.sess_id));
            bad += field_differs("sequence_res", 64'(want.sequence_res),
                                 64'(got.sequence_res));
            bad += field_differs("acknowledgement", 64'(want.acknowledgement),
                                 64'(got.acknowledgement));
            bad += field_differs("tx_stamp_us", want.tx_stamp_us, got.tx_stamp_us);
            if (bad != 0)
                mismatches++;
            if (want.item_kind == KIND_VERDICT)
                verdicts_seen[want.status]++;
            else
                payloads_seen++;
        endfunction
    endclass

endpackage

module framed_packet_checker_crc32c_tb
    import fpc_pkg::*;
    import frame_check_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PAYLOAD_CAP    = MAX_PAYLOAD_DEF;
    localparam int unsigned RANDOM_BYTES   = 520;
    localparam int unsigned PHASES         = 4;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;

    typedef enum int {
        FR_GOOD,
        FR_SHORT,
        FR_TOO_LARGE,
        FR_BAD_VER,
        FR_BAD_LEN,
        FR_BAD_CRC,
        FR_NOISE
    } frame_kind_e;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_e;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [7:0]  cfg_write_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_body;
    logic        out_valid;
    logic        out_ready;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [15:0] version;
    logic [7:0]  msg_type;
    logic [7:0]  flags;
    logic [15:0] declared_len;
    logic [31:0] sess_id;
    logic [31:0] sequence_res;
    logic [31:0] acknowledgement;
    logic [63:0] tx_stamp_us;

    frame_scoreboard sb;
    logic [7:0]      frame_bytes[$];
    logic [7:0]      cur_major;
    bit              rx_hold_req;
    int unsigned     cycle_count;
    int unsigned     bytes_sent;
    int unsigned     frames_sent;

    framed_packet_checker_crc32c #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_body    (end_of_body),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .item_kind      (item_kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .version        (version),
        .msg_type       (msg_type),
        .flags          (flags),
        .declared_len   (declared_len),
        .sess_id        (sess_id),
        .sequence_res   (sequence_res),
        .acknowledgement(acknowledgement),
        .tx_stamp_us    (tx_stamp_us)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({item_kind, payload_byte, status, version, msg_type, flags,
                             declared_len, sess_id, sequence_res, acknowledgement,
                             tx_stamp_us});
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, steady stretches, and one long counted hold-off on request
    initial
    begin : rx_side
        int unsigned stall_left;
        int unsigned steady_left;
        int unsigned r;
        out_ready   = 1'b0;
        stall_left  = 0;
        steady_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else if (steady_left != 0)
            begin
                steady_left--;
                out_ready <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    steady_left = $urandom_range(30, 150);
                    out_ready <= 1'b1;
                end
                else if (r < 35)
                begin
                    stall_left = pick_gap();
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] fill_byte(fill_e fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // size is the payload length for formatted frames, the whole body length otherwise
    function automatic void build_frame(frame_kind_e kind, int unsigned size, fill_e fill);
        logic [7:0]  hb[HDR_BYTES];
        logic [31:0] crc;
        int unsigned declared;
        int unsigned i;
        frame_bytes.delete();
        if (kind == FR_SHORT || kind == FR_NOISE)
        begin
            for (i = 0; i < size; i++)
                frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
            return;
        end
        foreach (hb[j])
            hb[j] = fill_byte(fill);
        hb[1] = cur_major;
        if (kind == FR_BAD_VER)
            hb[1] = cur_major ^ 8'($urandom_range(1, 255));
        declared = size;
        if (kind == FR_BAD_LEN)
        begin
            if ($urandom_range(0, 1) == 0)
                declared = $urandom_range(0, 65535);
            else
                declared = size + $urandom_range(1, 3);
            if (declared == size)
                declared = size + 1;
        end
        hb[4] = declared[7:0];
        hb[5] = declared[15:8];
        foreach (hb[j])
            frame_bytes = {frame_bytes, hb[j]};
        for (i = 0; i < size; i++)
            frame_bytes = {frame_bytes, fill_byte(fill)};
        crc = CRC_INIT;
        foreach (frame_bytes[j])
            crc = crc32c_step(crc, frame_bytes[j]);
        crc = crc ^ CRC_INIT;
        if (kind == FR_BAD_CRC)
            crc = crc ^ (32'h1 << $urandom_range(0, 31));
        for (i = 0; i < CRC_BYTES; i++)
            frame_bytes = {frame_bytes, crc[8*i +: 8]};
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input int unsigned gap);
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_body <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_kind_e kind, input int unsigned size,
                              input fill_e fill, input bit steady);
        int unsigned i;
        build_frame(kind, size, fill);
        for (i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, steady ? 0 : pick_gap());
        frames_sent++;
    endtask

    task automatic send_random_frame();
        int unsigned r;
        int unsigned plen;
        bit          steady;
        steady = ($urandom_range(0, 3) == 0);
        plen   = ($urandom_range(0, 24) == 0) ? $urandom_range(25, PAYLOAD_CAP)
                                              : $urandom_range(0, 24);
        r = $urandom_range(0, 99);
        if (r < 55)
            send_frame(FR_GOOD, plen, FILL_RANDOM, steady);
        else if (r < 63)
            send_frame(FR_BAD_VER, plen, FILL_RANDOM, steady);
        else if (r < 71)
            send_frame(FR_BAD_LEN, plen, FILL_RANDOM, steady);
        else if (r < 79)
            send_frame(FR_BAD_CRC, plen, FILL_RANDOM, steady);
        else if (r < 87)
            send_frame(FR_SHORT, $urandom_range(1, HDR_BYTES + CRC_BYTES - 1),
                       FILL_RANDOM, steady);
        else if (r < 90)
            send_frame(FR_TOO_LARGE, $urandom_range(PAYLOAD_CAP + 1, PAYLOAD_CAP + 14),
                       FILL_RANDOM, steady);
        else
            send_frame(FR_NOISE, $urandom_range(1, 60), FILL_RANDOM, steady);
    endtask

    // drop valid and hold until every expected transaction has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_major(input logic [7:0] value);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        sb.major  = value;
        cur_major = value;
    endtask

    initial
    begin : main
        logic [7:0]  phase_major[PHASES];
        int unsigned phase;
        int unsigned phase_start;
        bit          paused;
        sb             = new(PAYLOAD_CAP);
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        data_byte      = '0;
        end_of_body    = 1'b0;
        rx_hold_req    = 1'b0;
        cycle_count    = 0;
        bytes_sent     = 0;
        frames_sent    = 0;
        cur_major      = EXP_MAJOR_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed frames under the reset value of the major version
        send_frame(FR_GOOD, 0, FILL_ZERO, 1'b1);
        send_frame(FR_GOOD, 3, FILL_ONES, 1'b0);
        send_frame(FR_SHORT, 1, FILL_RANDOM, 1'b1);
        send_frame(FR_SHORT, HDR_BYTES + CRC_BYTES - 1, FILL_RANDOM, 1'b0);
        send_frame(FR_BAD_VER, 2, FILL_RANDOM, 1'b1);
        send_frame(FR_BAD_LEN, 5, FILL_RANDOM, 1'b0);
        send_frame(FR_BAD_CRC, 4, FILL_RANDOM, 1'b1);
        send_frame(FR_GOOD, PAYLOAD_CAP, FILL_RANDOM, 1'b0);
        send_frame(FR_TOO_LARGE, PAYLOAD_CAP + 1, FILL_RANDOM, 1'b1);
        drain_results();

        phase_major[0] = 8'h00;
        phase_major[1] = 8'hFF;
        phase_major[2] = 8'($urandom_range(2, 254));
        phase_major[3] = EXP_MAJOR_RST;
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_major(phase_major[phase]);
            phase_start = bytes_sent;
            paused      = 1'b0;
            if (phase == 1)
                rx_hold_req = 1'b1;
            while (bytes_sent - phase_start < RANDOM_BYTES / PHASES)
            begin
                send_random_frame();
                if (phase == 2 && !paused && bytes_sent - phase_start >= RANDOM_BYTES / 8)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
            drain_results();
        end

        $display("%0d frames, %0d body bytes sent over %0d major-version settings;",
                 frames_sent, bytes_sent, PHASES + 1);
        $display("%0d payload bytes checked; verdicts ok/short/large/version/length/crc: %0d/%0d/%0d/%0d/%0d/%0d",
                 sb.payloads_seen, sb.verdicts_seen[ST_OK], sb.verdicts_seen[ST_SHORT],
                 sb.verdicts_seen[ST_TOO_LARGE], sb.verdicts_seen[ST_BAD_VER],
                 sb.verdicts_seen[ST_BAD_LEN], sb.verdicts_seen[ST_BAD_CRC]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatched transactions, %0d still expected",
                     sb.mismatches, sb.pending());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
rtl/fpc_pkg.sv
rtl/fpc_crc_step.sv
rtl/fpc_frame.sv
rtl/framed_packet_checker_crc32c.sv
rtl/fpc_checker.sv
bench/framed_packet_checker_crc32c_tb.sv
